// ===== sv/qlsf_pkg.sv =====
// Shared types and constants of the quad light sensor EMA filter.
package qlsf_pkg;

  localparam int NUM_CHANNELS = 5;
  localparam int CH_W         = 3;
  localparam int FRAC_BITS    = 16;
  localparam int LEVEL_W      = 28;
  localparam int INT_W        = LEVEL_W - FRAC_BITS;
  localparam int DIFF_W       = INT_W + 1;
  localparam int ALPHA_W      = 16;

  localparam int SAMPLES_PER_READING_DEF = 16;
  localparam int SAMPLE_BITS_DEF         = 12;

  typedef logic [CH_W-1:0]          channel_t;
  typedef logic [LEVEL_W-1:0]       level_t;
  typedef logic [INT_W-1:0]         level_int_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic [ALPHA_W-1:0]       alpha_t;

  localparam channel_t CH_TOP_LEFT     = 3'd0;
  localparam channel_t CH_TOP_RIGHT    = 3'd1;
  localparam channel_t CH_BOTTOM_LEFT  = 3'd2;
  localparam channel_t CH_BOTTOM_RIGHT = 3'd3;

  localparam logic MODE_SEED = 1'b1;

  localparam alpha_t ALPHA_RESET = 16'd6554;
  localparam level_t LEVEL_RESET = {12'd2048, 16'd0};

endpackage

// ===== sv/qlsf_if.sv =====
// Valid/ready channel interfaces: sample input, result output, alpha write.
interface qlsf_sample_if #(
  parameter int SAMPLE_BITS = qlsf_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  qlsf_pkg::channel_t     channel;
  logic                   mode;

  modport source (output valid, sample, channel, mode, input ready);
  modport sink   (input valid, sample, channel, mode, output ready);
endinterface

interface qlsf_result_if;
  logic                 valid;
  logic                 ready;
  qlsf_pkg::channel_t   out_channel;
  qlsf_pkg::level_int_t level;
  qlsf_pkg::diff_t      vertical;
  qlsf_pkg::diff_t      horizontal;

  modport source (output valid, out_channel, level, vertical, horizontal, input ready);
  modport sink   (input valid, out_channel, level, vertical, horizontal, output ready);
endinterface

interface qlsf_cfg_if;
  logic               valid;
  logic               ready;
  qlsf_pkg::alpha_t   alpha;

  modport source (output valid, alpha, input ready);
  modport sink   (input valid, alpha, output ready);
endinterface

// ===== sv/quad_light_sensor_ema_filter.sv =====
// Top level: sample averaging, per-channel EMA levels and quad differentials.
//
// Samples arrive one per transfer, tagged with a channel (0 top-left, 1 top-right,
// 2 bottom-left, 3 bottom-right, 4 panel voltage) and a mode bit. Every
// SAMPLES_PER_READING accepted samples with a valid channel form one reading
// (sum divided by the count, truncated); samples tagged 5..7 are taken and
// dropped without touching the accumulator. The reading is credited to the
// channel and mode of the sample that completes it, whatever the channels of the
// earlier samples. Mode 1 loads the level with the reading, mode 0 moves the
// Q12.16 level toward it by alpha (Q0.16, written on the cfg channel, reset 6554),
// rounded half up. Each reading yields one result transfer: the channel, its
// integer level and the vertical/horizontal differentials of the four sensor
// levels. One sample per clock is taken while samples.ready is high; the completing
// sample passes the registers completed sum, reciprocal multiply, level update and
// differential/output before results.valid rises. Backpressure on the
// result side first fills the empty pipeline slots, then deasserts samples.ready.
// Levels reset to 2048.0 on all channels. cfg.ready is always high; alpha should
// only change while the pipeline is empty.
module quad_light_sensor_ema_filter #(
  parameter int SAMPLES_PER_READING = qlsf_pkg::SAMPLES_PER_READING_DEF,
  parameter int SAMPLE_BITS         = qlsf_pkg::SAMPLE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  qlsf_sample_if.sink   samples,
  qlsf_result_if.source results,
  qlsf_cfg_if.sink      cfg
);

  // Divide by the reading length as multiply by a rounded-up reciprocal.
  // With K = SUM_W + ceil(log2 N) the quotient is exact for every sum.
  localparam int CLOG_N    = $clog2(SAMPLES_PER_READING);
  localparam int SUM_W     = SAMPLE_BITS + CLOG_N;
  localparam int CNT_W     = $clog2(SAMPLES_PER_READING + 1);
  localparam int DIV_SHIFT = SUM_W + CLOG_N;
  localparam int MAG_W     = SUM_W + 2;
  localparam int PROD_W    = SUM_W + MAG_W;
  localparam logic [MAG_W-1:0] DIV_MAGIC =
    MAG_W'(((64'd1 << DIV_SHIFT) + 64'(SAMPLES_PER_READING) - 64'd1) /
           64'(SAMPLES_PER_READING));
  localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(SAMPLES_PER_READING - 1);

  function automatic qlsf_pkg::diff_t half_diff(
    input qlsf_pkg::level_int_t a,
    input qlsf_pkg::level_int_t b,
    input qlsf_pkg::level_int_t c,
    input qlsf_pkg::level_int_t d
  );
    logic [qlsf_pkg::INT_W:0] s0;
    logic [qlsf_pkg::INT_W:0] s1;
    s0 = {1'b0, a} + {1'b0, b};
    s1 = {1'b0, c} + {1'b0, d};
    half_diff = $signed({1'b0, s0[qlsf_pkg::INT_W:1]}) -
                $signed({1'b0, s1[qlsf_pkg::INT_W:1]});
  endfunction

  // ---- configuration --------------------------------------------------------
  qlsf_pkg::alpha_t alpha;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= qlsf_pkg::ALPHA_RESET;
    end else if (cfg.valid) begin
      alpha <= cfg.alpha;
    end
  end

  // ---- pipeline handshake ---------------------------------------------------
  logic v1, v2, v3, out_valid;
  logic rdy1, rdy2, rdy3, rdyo;

  assign rdyo = !out_valid || results.ready;
  assign rdy3 = !v3 || rdyo;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign samples.ready = rdy1;

  // ---- stage 0: accumulator -------------------------------------------------
  logic [SUM_W-1:0] sample_sum;
  logic [SUM_W-1:0] sum_upd;
  logic [CNT_W-1:0] sample_count;
  logic             take;
  logic             done;

  assign take    = samples.valid && rdy1 &&
                   (samples.channel < qlsf_pkg::CH_W'(qlsf_pkg::NUM_CHANNELS));
  assign done    = (sample_count == LAST_COUNT);
  assign sum_upd = sample_sum + SUM_W'(samples.sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
    end else if (take) begin
      if (done) begin
        sample_sum   <= '0;
        sample_count <= '0;
      end else begin
        sample_sum   <= sum_upd;
        sample_count <= sample_count + CNT_W'(1);
      end
    end
  end

  // ---- stage 1: completed sum -----------------------------------------------
  qlsf_pkg::channel_t ch1;
  logic               seed1;
  logic [SUM_W-1:0]   total1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= take && done;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      ch1    <= samples.channel;
      seed1  <= samples.mode;
      total1 <= sum_upd;
    end
  end

  // ---- stage 2: reading = total / N -----------------------------------------
  logic [PROD_W-1:0]      div_prod;
  qlsf_pkg::channel_t     ch2;
  logic                   seed2;
  logic [SAMPLE_BITS-1:0] reading2;

  assign div_prod = PROD_W'(total1) * PROD_W'(DIV_MAGIC);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      ch2      <= ch1;
      seed2    <= seed1;
      reading2 <= SAMPLE_BITS'(div_prod >> DIV_SHIFT);
    end
  end

  // ---- stage 3: level update ------------------------------------------------
  qlsf_pkg::level_t   levels [qlsf_pkg::NUM_CHANNELS];
  qlsf_pkg::level_t   new_level;
  qlsf_pkg::channel_t ch3;

  qlsf_ema_calc #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_ema (
    .cur_level (levels[ch2]),
    .reading   (reading2),
    .alpha     (alpha),
    .seed      (seed2),
    .new_level (new_level)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      for (int i = 0; i < qlsf_pkg::NUM_CHANNELS; i++) begin
        levels[i] <= qlsf_pkg::LEVEL_RESET;
      end
    end else if (rdy3) begin
      v3 <= v2;
      if (v2) begin
        levels[ch2] <= new_level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      ch3 <= ch2;
    end
  end

  // ---- output register: level and differentials ----------------------------
  // Levels already hold this item's update; a later update lands on the same
  // edge as this capture and is not seen.
  qlsf_pkg::level_int_t lv_tl, lv_tr, lv_bl, lv_br;
  qlsf_pkg::channel_t   out_channel;
  qlsf_pkg::level_int_t out_level;
  qlsf_pkg::diff_t      out_vertical;
  qlsf_pkg::diff_t      out_horizontal;

  assign lv_tl = levels[qlsf_pkg::CH_TOP_LEFT][qlsf_pkg::LEVEL_W-1:qlsf_pkg::FRAC_BITS];
  assign lv_tr = levels[qlsf_pkg::CH_TOP_RIGHT][qlsf_pkg::LEVEL_W-1:qlsf_pkg::FRAC_BITS];
  assign lv_bl = levels[qlsf_pkg::CH_BOTTOM_LEFT][qlsf_pkg::LEVEL_W-1:qlsf_pkg::FRAC_BITS];
  assign lv_br = levels[qlsf_pkg::CH_BOTTOM_RIGHT][qlsf_pkg::LEVEL_W-1:qlsf_pkg::FRAC_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdyo) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdyo) begin
      out_channel    <= ch3;
      out_level      <= levels[ch3][qlsf_pkg::LEVEL_W-1:qlsf_pkg::FRAC_BITS];
      out_vertical   <= half_diff(lv_tl, lv_tr, lv_bl, lv_br);
      out_horizontal <= half_diff(lv_tl, lv_bl, lv_tr, lv_br);
    end
  end

  assign results.valid       = out_valid;
  assign results.out_channel = out_channel;
  assign results.level       = out_level;
  assign results.vertical    = out_vertical;
  assign results.horizontal  = out_horizontal;

  // ---- checks ---------------------------------------------------------------
  localparam qlsf_pkg::diff_t DIFF_MAX = qlsf_pkg::DIFF_W'((1 << qlsf_pkg::INT_W) - 1);

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    sample_count <= LAST_COUNT)
    else $error("sample count passed the reading length");

  a_out_channel: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.out_channel < qlsf_pkg::CH_W'(qlsf_pkg::NUM_CHANNELS)))
    else $error("result for a channel that is never accumulated");

  a_diff_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.vertical <= DIFF_MAX && results.vertical >= -DIFF_MAX &&
                       results.horizontal <= DIFF_MAX && results.horizontal >= -DIFF_MAX))
    else $error("differential out of range");

  a_complete_clears: assert property (@(posedge clk) disable iff (rst)
    (take && done) |=> (sample_count == '0 && sample_sum == '0 && v1))
    else $error("completed reading did not restart the accumulator");

endmodule

// ===== sv/qlsf_ema_calc.sv =====
// Level update: seed with the reading or move toward it by alpha, rounded.
module qlsf_ema_calc #(
  parameter int SAMPLE_BITS = qlsf_pkg::SAMPLE_BITS_DEF
) (
  input  qlsf_pkg::level_t       cur_level,
  input  logic [SAMPLE_BITS-1:0] reading,
  input  qlsf_pkg::alpha_t       alpha,
  input  logic                   seed,
  output qlsf_pkg::level_t       new_level
);

  localparam int TGT_W = SAMPLE_BITS + qlsf_pkg::FRAC_BITS;
  localparam int D_W   = ((TGT_W > qlsf_pkg::LEVEL_W) ? TGT_W : qlsf_pkg::LEVEL_W) + 1;
  localparam int P_W   = D_W + qlsf_pkg::ALPHA_W + 1;
  localparam logic signed [P_W-1:0] ROUND_HALF = P_W'(1) << (qlsf_pkg::FRAC_BITS - 1);

  logic [TGT_W-1:0]        target;
  logic signed [D_W-1:0]   diff;
  logic signed [P_W-1:0]   prod;
  logic signed [P_W-1:0]   step;
  logic signed [P_W-1:0]   moved;

  assign target = {reading, {qlsf_pkg::FRAC_BITS{1'b0}}};
  assign diff   = $signed(D_W'(target)) - $signed(D_W'(cur_level));
  assign prod   = P_W'($signed({1'b0, alpha})) * P_W'(diff);
  // floor((alpha*d + half) / 2^16)
  assign step   = (prod + ROUND_HALF) >>> qlsf_pkg::FRAC_BITS;
  assign moved  = P_W'($signed({1'b0, cur_level})) + step;

  always_comb begin
    if (seed == qlsf_pkg::MODE_SEED) begin
      new_level = qlsf_pkg::LEVEL_W'(target);
    end else if (moved < 0) begin
      new_level = '0;
    end else begin
      new_level = moved[qlsf_pkg::LEVEL_W-1:0];
    end
  end

endmodule
